// ===== sv/cpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolve: shared package
// Widths, pipeline depths and the item records that travel down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cpcr_pkg;

    // Field widths.
    localparam int POS_W  = 24;     // Q15.8 position
    localparam int RAD_W  = 16;     // Q8.8 radius
    localparam int RSUM_W = 17;     // radius sum
    localparam int MAG_W  = 17;     // |dx| or |dy| when the circles overlap

    // Square root unit: radicand is dist2 * 2^16, below 2^50 when overlapping.
    localparam int SQ_W       = 50;
    localparam int ROOT_W     = 25;
    localparam int ROOT_STEPS = 25;

    // Divider: numerator mag * pen + dist, divisor 2 * dist.
    localparam int PEN_W    = 25;
    localparam int NUM_W    = 43;
    localparam int DEN_W    = 26;
    localparam int QUO_BITS = 17;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic        [RAD_W-1:0] rad_t;

    // Per-item data carried alongside the arithmetic units.
    typedef struct packed {
        pos_t             ax;
        pos_t             ay;
        pos_t             bx;
        pos_t             by;
        logic             over;
        logic             same;
        logic             neg_x;
        logic             neg_y;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
    } cpcr_item_t;

    // Data carried through the square root unit.
    typedef struct packed {
        logic [RSUM_W-1:0] rsum;
        cpcr_item_t        item;
    } cpcr_sq_side_t;

endpackage

`default_nettype wire

// ===== sv/cpcr_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolve: pipelined integer square root
// One result bit is settled per register stage; an item enters every cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_sqrt_pipe #(
    parameter int SIDE_W = 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [cpcr_pkg::SQ_W-1:0]    in_v,
    input  wire logic [SIDE_W-1:0]            in_side,
    output logic                              out_valid,
    output logic [cpcr_pkg::ROOT_W-1:0]       out_root,
    output logic [SIDE_W-1:0]                 out_side
);
    import cpcr_pkg::*;

    logic              vld_w    [0:ROOT_STEPS-1];
    logic [SQ_W-1:0]   rem_w    [0:ROOT_STEPS-1];
    logic [SQ_W-1:0]   root_w   [0:ROOT_STEPS-1];
    logic [SIDE_W-1:0] side_w   [0:ROOT_STEPS-1];
    logic              vld_reg  [0:ROOT_STEPS-1];
    logic [SQ_W-1:0]   rem_reg  [0:ROOT_STEPS-1];
    logic [SQ_W-1:0]   root_reg [0:ROOT_STEPS-1];
    logic [SIDE_W-1:0] side_reg [0:ROOT_STEPS-1];

    genvar i;
    generate
        for (i = 0; i < ROOT_STEPS; i++) begin : g_step
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - i));
            logic [SQ_W-1:0] trial;
            logic [SQ_W-1:0] rem_next;
            logic [SQ_W-1:0] root_next;

            // Step inputs come from the ports for the first stage.
            if (i == 0) begin : g_first
                assign vld_w[i]  = in_valid;
                assign rem_w[i]  = in_v;
                assign root_w[i] = '0;
                assign side_w[i] = in_side;
            end else begin : g_rest
                assign vld_w[i]  = vld_reg[i-1];
                assign rem_w[i]  = rem_reg[i-1];
                assign root_w[i] = root_reg[i-1];
                assign side_w[i] = side_reg[i-1];
            end

            // One restoring square root step.
            always_comb begin
                trial = root_w[i] + BIT;
                if (rem_w[i] >= trial) begin
                    rem_next  = rem_w[i] - trial;
                    root_next = (root_w[i] >> 1) + BIT;
                end else begin
                    rem_next  = rem_w[i];
                    root_next = root_w[i] >> 1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (en) begin
                    vld_reg[i] <= vld_w[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i]  <= rem_next;
                    root_reg[i] <= root_next;
                    side_reg[i] <= side_w[i];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_STEPS-1];
    assign out_root  = root_reg[ROOT_STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_STEPS-1];

endmodule

`default_nettype wire

// ===== sv/cpcr_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolve: pipelined dual-lane divider
// Two numerators share one divisor; one quotient bit per stage and lane.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_div_pipe #(
    parameter int SIDE_W = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [cpcr_pkg::NUM_W-1:0]    in_num_a,
    input  wire logic [cpcr_pkg::NUM_W-1:0]    in_num_b,
    input  wire logic [cpcr_pkg::DEN_W-1:0]    in_den,
    input  wire logic [SIDE_W-1:0]             in_side,
    output logic                               out_valid,
    output logic [cpcr_pkg::QUO_BITS-1:0]      out_quo_a,
    output logic [cpcr_pkg::QUO_BITS-1:0]      out_quo_b,
    output logic [SIDE_W-1:0]                  out_side
);
    import cpcr_pkg::*;

    logic                vld_w    [0:QUO_BITS-1];
    logic [NUM_W-1:0]    ra_w     [0:QUO_BITS-1];
    logic [NUM_W-1:0]    rb_w     [0:QUO_BITS-1];
    logic [QUO_BITS-1:0] qa_w     [0:QUO_BITS-1];
    logic [QUO_BITS-1:0] qb_w     [0:QUO_BITS-1];
    logic [DEN_W-1:0]    den_w    [0:QUO_BITS-1];
    logic [SIDE_W-1:0]   side_w   [0:QUO_BITS-1];
    logic                vld_reg  [0:QUO_BITS-1];
    logic [NUM_W-1:0]    ra_reg   [0:QUO_BITS-1];
    logic [NUM_W-1:0]    rb_reg   [0:QUO_BITS-1];
    logic [QUO_BITS-1:0] qa_reg   [0:QUO_BITS-1];
    logic [QUO_BITS-1:0] qb_reg   [0:QUO_BITS-1];
    logic [DEN_W-1:0]    den_reg  [0:QUO_BITS-1];
    logic [SIDE_W-1:0]   side_reg [0:QUO_BITS-1];

    genvar i;
    generate
        for (i = 0; i < QUO_BITS; i++) begin : g_step
            localparam int SH = QUO_BITS - 1 - i;
            logic [NUM_W-1:0]    trial;
            logic [NUM_W-1:0]    ra_next;
            logic [NUM_W-1:0]    rb_next;
            logic [QUO_BITS-1:0] qa_next;
            logic [QUO_BITS-1:0] qb_next;

            if (i == 0) begin : g_first
                assign vld_w[i]  = in_valid;
                assign ra_w[i]   = in_num_a;
                assign rb_w[i]   = in_num_b;
                assign qa_w[i]   = '0;
                assign qb_w[i]   = '0;
                assign den_w[i]  = in_den;
                assign side_w[i] = in_side;
            end else begin : g_rest
                assign vld_w[i]  = vld_reg[i-1];
                assign ra_w[i]   = ra_reg[i-1];
                assign rb_w[i]   = rb_reg[i-1];
                assign qa_w[i]   = qa_reg[i-1];
                assign qb_w[i]   = qb_reg[i-1];
                assign den_w[i]  = den_reg[i-1];
                assign side_w[i] = side_reg[i-1];
            end

            // Subtract the shifted divisor where it fits, in both lanes.
            always_comb begin
                trial   = NUM_W'(den_w[i]) << SH;
                ra_next = ra_w[i];
                rb_next = rb_w[i];
                qa_next = qa_w[i];
                qb_next = qb_w[i];
                if (ra_w[i] >= trial) begin
                    ra_next     = ra_w[i] - trial;
                    qa_next[SH] = 1'b1;
                end
                if (rb_w[i] >= trial) begin
                    rb_next     = rb_w[i] - trial;
                    qb_next[SH] = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (en) begin
                    vld_reg[i] <= vld_w[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    ra_reg[i]   <= ra_next;
                    rb_reg[i]   <= rb_next;
                    qa_reg[i]   <= qa_next;
                    qb_reg[i]   <= qb_next;
                    den_reg[i]  <= den_w[i];
                    side_reg[i] <= side_w[i];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QUO_BITS-1];
    assign out_quo_a = qa_reg[QUO_BITS-1];
    assign out_quo_b = qb_reg[QUO_BITS-1];
    assign out_side  = side_reg[QUO_BITS-1];

endmodule

`default_nettype wire

// ===== sv/circle_pair_collision_resolve.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolve: top level
// Pushes two overlapping circles apart along their centre line.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: two centres (signed Q15.8) and two radii (Q8.8) per
//   transfer. Result channel m_*: the corrected centres, saturated to Q15.8,
//   with the overlapped and coincident flags. One result per input transfer.
//   From input transfer to result valid each pair passes through three front
//   stages (difference, squares, compare), 25 square root stages, two stages
//   for depth and products, 17 divider stages and the output register.
//   Throughput is one pair per cycle unless the output stalls; every stage is a
//   register with its own valid bit, so bubbles pass without costing extra cycles.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_ready falls; nothing is lost or repeated. A synchronous active-low
//   reset clears all valid bits; payload registers are not reset.
//   Pairs that do not overlap, or whose centres coincide, pass their centres
//   through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_pair_collision_resolve (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire cpcr_pkg::pos_t s_first_x,
    input  wire cpcr_pkg::pos_t s_first_y,
    input  wire cpcr_pkg::rad_t s_first_radius,
    input  wire cpcr_pkg::pos_t s_second_x,
    input  wire cpcr_pkg::pos_t s_second_y,
    input  wire cpcr_pkg::rad_t s_second_radius,
    output logic                m_valid,
    input  wire logic           m_ready,
    output cpcr_pkg::pos_t      m_new_first_x,
    output cpcr_pkg::pos_t      m_new_first_y,
    output cpcr_pkg::pos_t      m_new_second_x,
    output cpcr_pkg::pos_t      m_new_second_y,
    output logic                m_overlapped,
    output logic                m_coincident
);
    import cpcr_pkg::*;

    localparam int SQ_SIDE_W  = $bits(cpcr_sq_side_t);
    localparam int DIV_SIDE_W = $bits(cpcr_item_t);

    // Saturate a wide signed sum to the position range.
    function automatic pos_t sat_pos(input logic signed [POS_W+1:0] v);
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        begin
            hi = (POS_W+2)'(2 ** (POS_W - 1) - 1);
            lo = -(POS_W+2)'(2 ** (POS_W - 1));
            if (v > hi) begin
                sat_pos = hi[POS_W-1:0];
            end else if (v < lo) begin
                sat_pos = lo[POS_W-1:0];
            end else begin
                sat_pos = v[POS_W-1:0];
            end
        end
    endfunction

    logic en;

    // Stage 1: centre differences and radius sum.
    logic                    s1_vld_reg;
    pos_t                    s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic signed [POS_W:0]   s1_dx_reg, s1_dy_reg;
    logic [RSUM_W-1:0]       s1_rsum_reg;

    // Stage 2: squares.
    logic                    s2_vld_reg;
    pos_t                    s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg;
    logic signed [POS_W:0]   s2_dx_reg, s2_dy_reg;
    logic [RSUM_W-1:0]       s2_rsum_reg;
    logic signed [2*POS_W+1:0] s2_dx2_next, s2_dy2_next;
    logic [2*POS_W+1:0]      s2_dx2_reg, s2_dy2_reg;
    logic [2*RSUM_W-1:0]     s2_rs2_reg;

    // Stage 3: overlap test and radicand.
    logic                    s3_vld_reg;
    logic [2*POS_W+2:0]      s3_dist2;
    logic [POS_W:0]          s3_absx, s3_absy;
    cpcr_sq_side_t           s3_side_next, s3_side_reg;
    logic [SQ_W-1:0]         s3_v_next, s3_v_reg;

    // Square root output.
    logic                    sq_vld;
    logic [ROOT_W-1:0]       sq_root;
    cpcr_sq_side_t           sq_side;

    // Stage 4: penetration depth.
    logic                    s4_vld_reg;
    cpcr_item_t              s4_item_reg;
    logic [ROOT_W-1:0]       s4_dist_reg;
    logic [PEN_W-1:0]        s4_pen_reg;

    // Stage 5: dividend products.
    logic                    s5_vld_reg;
    cpcr_item_t              s5_item_reg;
    logic [NUM_W-1:0]        s5_num_x_reg, s5_num_y_reg;
    logic [DEN_W-1:0]        s5_den_reg;

    // Divider output.
    logic                    dv_vld;
    logic [QUO_BITS-1:0]     dv_qx, dv_qy;
    logic [DIV_SIDE_W-1:0]   dv_side_bits;
    cpcr_item_t              dv_item;
    logic signed [QUO_BITS:0] sh_x, sh_y;

    // Output register.
    logic                    out_vld_reg;
    pos_t                    nax_next, nay_next, nbx_next, nby_next;
    pos_t                    nax_reg, nay_reg, nbx_reg, nby_reg;
    logic                    over_reg, same_reg;

    // The whole pipeline advances unless a result is stuck at the output.
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    // Valid bits of the front and back stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg  <= s_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= sq_vld;
            s5_vld_reg  <= s4_vld_reg;
            out_vld_reg <= dv_vld;
        end
    end

    // Stage 1 payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ax_reg   <= s_first_x;
            s1_ay_reg   <= s_first_y;
            s1_bx_reg   <= s_second_x;
            s1_by_reg   <= s_second_y;
            s1_dx_reg   <= {s_second_x[POS_W-1], s_second_x}
                         - {s_first_x[POS_W-1], s_first_x};
            s1_dy_reg   <= {s_second_y[POS_W-1], s_second_y}
                         - {s_first_y[POS_W-1], s_first_y};
            s1_rsum_reg <= {1'b0, s_first_radius} + {1'b0, s_second_radius};
        end
    end

    // Stage 2 payload: three independent multipliers.
    assign s2_dx2_next = s1_dx_reg * s1_dx_reg;
    assign s2_dy2_next = s1_dy_reg * s1_dy_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_bx_reg   <= s1_bx_reg;
            s2_by_reg   <= s1_by_reg;
            s2_dx_reg   <= s1_dx_reg;
            s2_dy_reg   <= s1_dy_reg;
            s2_rsum_reg <= s1_rsum_reg;
            s2_dx2_reg  <= s2_dx2_next;
            s2_dy2_reg  <= s2_dy2_next;
            s2_rs2_reg  <= s1_rsum_reg * s1_rsum_reg;
        end
    end

    // Stage 3: distance squared against radius sum squared.
    always_comb begin
        s3_dist2 = {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};
        s3_absx  = s2_dx_reg[POS_W] ? (POS_W+1)'(0) - s2_dx_reg : s2_dx_reg;
        s3_absy  = s2_dy_reg[POS_W] ? (POS_W+1)'(0) - s2_dy_reg : s2_dy_reg;
        s3_side_next.rsum       = s2_rsum_reg;
        s3_side_next.item.ax    = s2_ax_reg;
        s3_side_next.item.ay    = s2_ay_reg;
        s3_side_next.item.bx    = s2_bx_reg;
        s3_side_next.item.by    = s2_by_reg;
        s3_side_next.item.over  = s3_dist2 < (2*POS_W+3)'(s2_rs2_reg);
        s3_side_next.item.same  = s3_side_next.item.over && (s3_dist2 == '0);
        s3_side_next.item.neg_x = s2_dx_reg[POS_W];
        s3_side_next.item.neg_y = s2_dy_reg[POS_W];
        s3_side_next.item.mag_x = s3_absx[MAG_W-1:0];
        s3_side_next.item.mag_y = s3_absy[MAG_W-1:0];
        // Only meaningful when overlapping, where dist2 fits in 34 bits.
        s3_v_next = {s3_dist2[SQ_W-17:0], 16'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_side_reg <= s3_side_next;
            s3_v_reg    <= s3_v_next;
        end
    end

    // Distance in Q.16.
    cpcr_sqrt_pipe #(
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_vld_reg),
        .in_v      (s3_v_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Stage 4: penetration depth, radius sum minus distance.
    always_ff @(posedge aclk) begin
        if (en) begin
            s4_item_reg <= sq_side.item;
            s4_dist_reg <= sq_root;
            s4_pen_reg  <= {sq_side.rsum, 8'b0} - sq_root;
        end
    end

    // Stage 5: rounded dividends and the doubled distance as divisor.
    always_ff @(posedge aclk) begin
        if (en) begin
            s5_item_reg  <= s4_item_reg;
            s5_num_x_reg <= NUM_W'(s4_item_reg.mag_x) * NUM_W'(s4_pen_reg)
                          + NUM_W'(s4_dist_reg);
            s5_num_y_reg <= NUM_W'(s4_item_reg.mag_y) * NUM_W'(s4_pen_reg)
                          + NUM_W'(s4_dist_reg);
            s5_den_reg   <= {s4_dist_reg, 1'b0};
        end
    end

    cpcr_div_pipe #(
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s5_vld_reg),
        .in_num_a  (s5_num_x_reg),
        .in_num_b  (s5_num_y_reg),
        .in_den    (s5_den_reg),
        .in_side   (s5_item_reg),
        .out_valid (dv_vld),
        .out_quo_a (dv_qx),
        .out_quo_b (dv_qy),
        .out_side  (dv_side_bits)
    );

    // Final stage: signed push, applied to both centres of an overlapping, non-coincident pair, then saturated.
    always_comb begin
        dv_item = cpcr_item_t'(dv_side_bits);
        sh_x = dv_item.neg_x ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
        sh_y = dv_item.neg_y ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
        if (dv_item.over && !dv_item.same) begin
            nax_next = sat_pos({{2{dv_item.ax[POS_W-1]}}, dv_item.ax}
                               - {{(POS_W+1-QUO_BITS){sh_x[QUO_BITS]}}, sh_x});
            nay_next = sat_pos({{2{dv_item.ay[POS_W-1]}}, dv_item.ay}
                               - {{(POS_W+1-QUO_BITS){sh_y[QUO_BITS]}}, sh_y});
            nbx_next = sat_pos({{2{dv_item.bx[POS_W-1]}}, dv_item.bx}
                               + {{(POS_W+1-QUO_BITS){sh_x[QUO_BITS]}}, sh_x});
            nby_next = sat_pos({{2{dv_item.by[POS_W-1]}}, dv_item.by}
                               + {{(POS_W+1-QUO_BITS){sh_y[QUO_BITS]}}, sh_y});
        end else begin
            nax_next = dv_item.ax;
            nay_next = dv_item.ay;
            nbx_next = dv_item.bx;
            nby_next = dv_item.by;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nax_reg  <= nax_next;
            nay_reg  <= nay_next;
            nbx_reg  <= nbx_next;
            nby_reg  <= nby_next;
            over_reg <= dv_item.over;
            same_reg <= dv_item.same;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_new_first_x  = nax_reg;
    assign m_new_first_y  = nay_reg;
    assign m_new_second_x = nbx_reg;
    assign m_new_second_y = nby_reg;
    assign m_overlapped   = over_reg;
    assign m_coincident   = same_reg;

endmodule

`default_nettype wire

// ===== sv/cpcr_checker.sv =====
// ----------------------------------------------------------------------------
// Circle pair collision resolve: port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module cpcr_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire cpcr_pkg::pos_t m_new_first_x,
    input wire cpcr_pkg::pos_t m_new_first_y,
    input wire cpcr_pkg::pos_t m_new_second_x,
    input wire cpcr_pkg::pos_t m_new_second_y,
    input wire logic           m_overlapped,
    input wire logic           m_coincident
);

    // Reset empties the pipeline: no result in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // Coincident centres are only reported for overlapping pairs.
    a_coincident_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_coincident |-> m_overlapped)
        else $error("coincident flagged without overlap");

    // The input side is held exactly when a result is stalled.
    a_ready_follows_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow the output stall");

    // A stalled result holds its value.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_first_x)
            && $stable(m_new_first_y) && $stable(m_new_second_x)
            && $stable(m_new_second_y) && $stable(m_overlapped)
            && $stable(m_coincident))
        else $error("stalled result changed");

endmodule

bind circle_pair_collision_resolve cpcr_checker u_cpcr_checker (.*);

`default_nettype wire
